// File: hdl/bmpenc_pkg.sv
// Shared types, constants and header builder for the BMP stream encoder.
package bmpenc_pkg;

    // Dimension limit and field widths
    localparam int MAX_DIM       = 16384;
    localparam int DIM_W         = 15;
    localparam int COL_W         = 14;
    localparam int ROW_BYTES_W   = 17;
    localparam int SIZE_W        = 32;
    localparam int BEAT_BYTES    = 8;
    localparam int BEAT_W        = 8 * BEAT_BYTES;
    localparam int CNT_W         = 4;
    localparam int HDR_MAX_BYTES = 128;
    localparam int BEAT_IDX_W    = 4;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd2;

    // Header modes
    localparam logic [1:0] MODE_INFO = 2'd0;
    localparam logic [1:0] MODE_V3   = 2'd1;
    localparam logic [1:0] MODE_V4   = 2'd2;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Header constants
    localparam logic [31:0] FILE_HDR_BYTES = 32'd14;
    localparam logic [31:0] MASK_RED       = 32'h00ff0000;
    localparam logic [31:0] MASK_GREEN     = 32'h0000ff00;
    localparam logic [31:0] MASK_BLUE      = 32'h000000ff;
    localparam logic [31:0] MASK_ALPHA     = 32'hff000000;
    localparam logic [31:0] COMP_RGB       = 32'd0;
    localparam logic [31:0] COMP_BITFIELDS = 32'd3;

    // One job handed from front to back
    typedef struct packed {
        logic                   is_hdr;
        logic [1:0]             mode;
        logic                   done;
        logic [CNT_W-1:0]       pcount;
        logic [31:0]            pbytes;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
        logic [SIZE_W-1:0]      img;
    } t_entry;

    // Information header size by mode
    function automatic logic [31:0] info_size(input logic [1:0] mode);
        case (mode)
            MODE_INFO: info_size = 32'd40;
            MODE_V3:   info_size = 32'd56;
            default:   info_size = 32'd108;
        endcase
    endfunction

    // Index of the last header beat by mode
    function automatic logic [BEAT_IDX_W-1:0] hdr_last(input logic [1:0] mode);
        case (mode)
            MODE_INFO: hdr_last = 4'd6;
            MODE_V3:   hdr_last = 4'd8;
            default:   hdr_last = 4'd15;
        endcase
    endfunction

    // Byte count of the last header beat by mode
    function automatic logic [CNT_W-1:0] hdr_tail(input logic [1:0] mode);
        case (mode)
            MODE_INFO: hdr_tail = 4'd6;
            MODE_V3:   hdr_tail = 4'd6;
            default:   hdr_tail = 4'd2;
        endcase
    endfunction

    // Build the whole header, first byte in the low bits, zero beyond its end
    function automatic logic [8*HDR_MAX_BYTES-1:0] hdr_image(
        input logic [1:0]        mode,
        input logic [DIM_W-1:0]  width,
        input logic [DIM_W-1:0]  height,
        input logic [SIZE_W-1:0] img
    );
        logic [8*HDR_MAX_BYTES-1:0] v;
        logic [31:0]                hsize;
        logic [31:0]                offset;
        v      = '0;
        hsize  = info_size(mode);
        offset = FILE_HDR_BYTES + hsize;
        v[0*8  +: 8]  = 8'h42;
        v[1*8  +: 8]  = 8'h4D;
        v[2*8  +: 32] = offset + img;
        v[10*8 +: 32] = offset;
        v[14*8 +: 32] = hsize;
        v[18*8 +: 32] = {{(32-DIM_W){1'b0}}, width};
        v[22*8 +: 32] = {{(32-DIM_W){1'b0}}, height};
        v[26*8 +: 16] = 16'd1;
        v[28*8 +: 16] = (mode == MODE_INFO) ? 16'd24 : 16'd32;
        v[30*8 +: 32] = (mode == MODE_INFO) ? COMP_RGB : COMP_BITFIELDS;
        v[34*8 +: 32] = img;
        if (mode != MODE_INFO) begin
            v[54*8 +: 32] = MASK_RED;
            v[58*8 +: 32] = MASK_GREEN;
            v[62*8 +: 32] = MASK_BLUE;
            v[66*8 +: 32] = MASK_ALPHA;
        end
        hdr_image = v;
    endfunction

endpackage

// File: hdl/bmpenc_front.sv
// Front end: configuration, input acceptance, frame tracking and job build.
module bmpenc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [31:0]                       i_s_axis_tdata,
    input  logic                              i_s_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [bmpenc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bmpenc_pkg::DIM_W-1:0]      i_cfg_wdata,
    input  logic                              i_pop,
    output logic                              o_push,
    output bmpenc_pkg::t_entry                o_entry
);
    import bmpenc_pkg::*;

    logic [DIM_W-1:0]       r_width, r_height;
    logic [1:0]             r_mode;
    logic [COL_W-1:0]       r_col, n_col;
    logic [DIM_W-1:0]       r_rows, n_rows;
    logic                   r_active, n_active;
    logic [QCNT_W-1:0]      r_used, n_used;
    logic                   r_a_valid;
    t_entry                 r_a_entry, n_entry;
    logic [ROW_BYTES_W-1:0] r_a_row_bytes, n_row_bytes;

    logic [1:0]             mode_eff;
    logic [DIM_W-1:0]       w_eff, h_eff;
    logic [ROW_BYTES_W-1:0] three_w;
    logic                   accept, push_a, end_row, end_frame;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            clamp_dim = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            clamp_dim = DIM_W'(MAX_DIM);
        else
            clamp_dim = v;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_mode   <= MODE_INFO;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_height <= i_cfg_wdata;
                CFG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                default:    ;
            endcase
        end
    end

    // Effective settings
    assign mode_eff = (r_mode == 2'd3) ? MODE_V4 : r_mode;
    assign w_eff    = clamp_dim(r_width);
    assign h_eff    = clamp_dim(r_height);
    assign three_w  = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
    assign n_row_bytes = (mode_eff == MODE_INFO) ? ((three_w + 17'd3) & ~17'd3)
                                                 : {w_eff, 2'b00};

    // Take a beat while the queue has a free slot
    assign o_s_axis_tready = (r_used < QCNT_W'(QDEPTH));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign push_a          = accept && ((i_s_axis_tuser == REQ_START) || r_active);

    // Classify the beat and advance the frame position
    assign end_row   = ({1'b0, r_col} + DIM_W'(1)) >= w_eff;
    assign end_frame = ({1'b0, r_rows} + 16'd1) >= {1'b0, h_eff};

    always_comb begin
        n_col    = r_col;
        n_rows   = r_rows;
        n_active = r_active;
        n_entry  = '0;
        n_entry.mode   = mode_eff;
        n_entry.width  = w_eff;
        n_entry.height = h_eff;
        if (i_s_axis_tuser == REQ_START) begin
            n_entry.is_hdr = 1'b1;
            n_col    = '0;
            n_rows   = '0;
            n_active = 1'b1;
        end else begin
            n_entry.pbytes = {(mode_eff == MODE_INFO) ? 8'h00 : i_s_axis_tdata[31:24],
                              i_s_axis_tdata[7:0], i_s_axis_tdata[15:8],
                              i_s_axis_tdata[23:16]};
            n_entry.pcount = (mode_eff == MODE_INFO) ? CNT_W'(3) : CNT_W'(4);
            if (end_row) begin
                if (mode_eff == MODE_INFO)
                    n_entry.pcount = CNT_W'(3) + {2'b00, w_eff[1:0]};
                n_col = '0;
                if (end_frame) begin
                    n_rows   = '0;
                    n_active = 1'b0;
                    n_entry.done = 1'b1;
                end else begin
                    n_rows = r_rows + DIM_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Frame state and staging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_rows    <= '0;
            r_active  <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= push_a;
            if (push_a) begin
                r_col    <= n_col;
                r_rows   <= n_rows;
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_a) begin
            r_a_entry     <= n_entry;
            r_a_row_bytes <= n_row_bytes;
        end
    end

    // Slot count over staging register and queue
    always_comb begin
        case ({push_a, i_pop})
            2'b10:   n_used = r_used + QCNT_W'(1);
            2'b01:   n_used = r_used - QCNT_W'(1);
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_used <= '0;
        else
            r_used <= n_used;
    end

    // Image size multiply on the way into the queue
    always_comb begin
        o_entry     = r_a_entry;
        o_entry.img = {{(SIZE_W-ROW_BYTES_W){1'b0}}, r_a_row_bytes}
                    * {{(SIZE_W-DIM_W){1'b0}}, r_a_entry.height};
    end

    assign o_push = r_a_valid;

endmodule

// File: hdl/bmpenc_queue.sv
// Short job queue between the front end and the output sequencer.
module bmpenc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bmpenc_pkg::t_entry i_entry,
    input  logic               i_pop,
    output logic               o_valid,
    output bmpenc_pkg::t_entry o_entry
);
    import bmpenc_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    // Store incoming job
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_entry;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + QPTR_W'(1);
            if (i_pop)
                r_rp <= r_rp + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rp];

endmodule

// File: hdl/bmpenc_back.sv
// Back end: turns queued jobs into output beats through an output register.
module bmpenc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  bmpenc_pkg::t_entry              i_entry,
    output logic                            o_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [bmpenc_pkg::BEAT_W+7:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    output logic                            o_m_axis_tuser
);
    import bmpenc_pkg::*;

    logic [BEAT_IDX_W-1:0]      r_beat, n_beat;
    logic                       r_out_valid;
    logic [BEAT_W-1:0]          r_out_bytes, n_bytes;
    logic [CNT_W-1:0]           r_out_count, n_count;
    logic                       r_out_last, r_out_done;
    logic [8*HDR_MAX_BYTES-1:0] hdr_v;
    logic                       can_load, fire, last_beat;

    assign can_load  = !r_out_valid || i_m_axis_tready;
    assign fire      = i_valid && can_load;
    assign last_beat = !i_entry.is_hdr || (r_beat == hdr_last(i_entry.mode));
    assign o_pop     = fire && last_beat;

    // Select the beat of the current job
    assign hdr_v = hdr_image(i_entry.mode, i_entry.width, i_entry.height, i_entry.img);

    always_comb begin
        if (i_entry.is_hdr) begin
            n_bytes = hdr_v[{r_beat, 6'b000000} +: BEAT_W];
            n_count = last_beat ? hdr_tail(i_entry.mode) : CNT_W'(BEAT_BYTES);
        end else begin
            n_bytes = {{(BEAT_W-32){1'b0}}, i_entry.pbytes};
            n_count = i_entry.pcount;
        end
    end

    // Advance the beat index within a header run
    always_comb begin
        n_beat = r_beat;
        if (fire)
            n_beat = last_beat ? '0 : r_beat + BEAT_IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
            if (fire)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // Load the output register, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_bytes <= n_bytes;
            r_out_count <= n_count;
            r_out_last  <= last_beat;
            r_out_done  <= !i_entry.is_hdr && i_entry.done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_count, r_out_bytes};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_done;

endmodule

// File: hdl/bmp_image_stream_encoder_core.sv
// Top level of the BMP stream encoder: front end, job queue and output sequencer.
// Writes a 24-bit (mode 0) or 32-bit (modes 1 to 3) BMP file as a byte stream, up to
// eight bytes per output beat, first byte in the low bits. A start beat (tuser 0) emits
// the file and information headers as 7, 9 or 16 output beats for mode 0, 1 or 2/3; each
// pixel beat (tuser 1) emits exactly one output beat of B,G,R(,A) plus the row padding
// after the last pixel of a row, and image_done marks the file's final beat. Pixels come
// bottom row first; pixels outside a frame are dropped. Input is accepted at one beat
// per cycle while the four-entry job queue has room; the output side delivers one beat
// per cycle while not stalled, so pixels sustain one per cycle and a header holds the
// output for all of its beats. Input passes through the staging register with the
// image-size multiply, the queue and the output register.
// Configuration is taken at once through the write port and should change only while
// the block is idle.
module bmp_image_stream_encoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [31:0]                       i_s_axis_tdata,
    // tuser: req_type
    input  logic                              i_s_axis_tuser,
    // tdata: out_bytes[63:0], byte_count[67:64], zero fill[71:68]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bmpenc_pkg::BEAT_W+7:0]     o_m_axis_tdata,
    // tlast: run_last
    output logic                              o_m_axis_tlast,
    // tuser: image_done
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [bmpenc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bmpenc_pkg::DIM_W-1:0]      i_cfg_wdata
);
    import bmpenc_pkg::*;

    logic   push, pop, q_valid;
    t_entry push_entry, head_entry;

    bmpenc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pop           (pop),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    bmpenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    bmpenc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// File: hdl/bmpenc_checker.sv
// Port-level checks for the BMP stream encoder, bound to the top level.
module bmpenc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [bmpenc_pkg::BEAT_W+7:0] o_m_axis_tdata,
    input logic                          o_m_axis_tlast,
    input logic                          o_m_axis_tuser
);
    import bmpenc_pkg::*;

    // Output register is empty right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output beat changed");

    // Byte count within one to eight
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[BEAT_W+3:BEAT_W] != 4'd0)
                         && (o_m_axis_tdata[BEAT_W+3:BEAT_W] <= 4'd8))
        else $error("byte count out of range");

    // Only the last beat of a run may be short
    a_full_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[BEAT_W+3:BEAT_W] == 4'd8)
        else $error("short beat inside a run");

    // File end is always a run end
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("image done without run end");

endmodule

bind bmp_image_stream_encoder_core bmpenc_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
